>>> design/gss_pkg.sv
// gss_pkg: shared types and constants for the gear shift selector.
// No dependencies; used by gss_cfg, gss_cmp and gear_shift_selector.
package gss_pkg;

    localparam int GEAR_W   = 4;
    localparam int RPM_W    = 16;
    localparam int TIME_W   = 32;
    localparam int GUARD_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W = 48;   // rpm + now_ms, already whole bytes
    localparam int M_TDATA_W = 8;    // selected_gear padded to a byte

    localparam logic [GEAR_W-1:0] GEAR_ONE = GEAR_W'(1);
    localparam logic [GEAR_W-1:0] GEAR_COUNT_RESET = GEAR_W'(6);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_HIGH = 3'd7;

    typedef enum logic [1:0] {
        THR_UP,
        THR_DOWN,
        THR_BRAKE
    } thr_kind_t;

    typedef struct packed {
        thr_kind_t         kind;
        logic [GEAR_W-1:0] gear;
    } thr_req_t;

    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

endpackage

>>> design/gss_cfg.sv
// gss_cfg: configuration registers and threshold lane lookup.
// Depends on gss_pkg.
module gss_cfg #(
    parameter int MAX_GEARS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [gss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  gss_pkg::thr_req_t                   thr_req,
    output logic signed [gss_pkg::RPM_W-1:0]    thr_value,
    output logic [gss_pkg::GEAR_W-1:0]          count_eff,
    output logic [gss_pkg::GUARD_W-1:0]         guard_ms
);

    localparam int LANE_W = (MAX_GEARS > 1) ? $clog2(MAX_GEARS) : 1;
    localparam logic [gss_pkg::GEAR_W-1:0] MAX_G = gss_pkg::GEAR_W'(MAX_GEARS);

    logic [gss_pkg::GEAR_W-1:0]       count_reg;
    logic [gss_pkg::GUARD_W-1:0]      guard_reg;
    logic signed [gss_pkg::RPM_W-1:0] up_reg    [MAX_GEARS];
    logic signed [gss_pkg::RPM_W-1:0] down_reg  [MAX_GEARS];
    logic signed [gss_pkg::RPM_W-1:0] brake_reg [MAX_GEARS];
    logic [gss_pkg::GEAR_W-1:0]       gear_m1;
    logic [LANE_W-1:0]                lane;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= gss_pkg::GEAR_COUNT_RESET;
            guard_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == gss_pkg::CFG_GEAR_COUNT)
                count_reg <= cfg_data[gss_pkg::GEAR_W-1:0];
            if (cfg_index == gss_pkg::CFG_GUARD_MS)
                guard_reg <= cfg_data[gss_pkg::GUARD_W-1:0];
        end
    end

    // only lanes of gears that can ever be current are kept
    for (genvar l = 0; l < MAX_GEARS; l++) begin : g_lane
        localparam int GRP = l / 4;
        localparam int POS = l % 4;
        localparam logic [gss_pkg::CFG_IDX_W-1:0] UP_IDX =
            gss_pkg::CFG_IDX_W'(int'(gss_pkg::CFG_UP_LOW) + GRP);
        localparam logic [gss_pkg::CFG_IDX_W-1:0] DN_IDX =
            gss_pkg::CFG_IDX_W'(int'(gss_pkg::CFG_DOWN_LOW) + GRP);
        localparam logic [gss_pkg::CFG_IDX_W-1:0] BR_IDX =
            gss_pkg::CFG_IDX_W'(int'(gss_pkg::CFG_BRAKE_LOW) + GRP);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                up_reg[l]    <= '0;
                down_reg[l]  <= '0;
                brake_reg[l] <= '0;
            end else if (cfg_valid) begin
                if (cfg_index == UP_IDX)
                    up_reg[l] <= cfg_data[gss_pkg::RPM_W*POS +: gss_pkg::RPM_W];
                if (cfg_index == DN_IDX)
                    down_reg[l] <= cfg_data[gss_pkg::RPM_W*POS +: gss_pkg::RPM_W];
                if (cfg_index == BR_IDX)
                    brake_reg[l] <= cfg_data[gss_pkg::RPM_W*POS +: gss_pkg::RPM_W];
            end
        end
    end

    assign gear_m1 = thr_req.gear - gss_pkg::GEAR_ONE;
    assign lane    = gear_m1[LANE_W-1:0];

    always_comb begin
        unique case (thr_req.kind)
            gss_pkg::THR_UP:    thr_value = up_reg[lane];
            gss_pkg::THR_DOWN:  thr_value = down_reg[lane];
            gss_pkg::THR_BRAKE: thr_value = brake_reg[lane];
            default:            thr_value = '0;
        endcase
    end

    // gear count saturated to 1..MAX_GEARS
    always_comb begin
        if (count_reg == '0)
            count_eff = gss_pkg::GEAR_ONE;
        else if (count_reg > MAX_G)
            count_eff = MAX_G;
        else
            count_eff = count_reg;
    end

    assign guard_ms = guard_reg;

endmodule

>>> design/gss_cmp.sv
// gss_cmp: shared signed 16-bit comparator used by the PREP, UP and SCAN steps.
// Depends on gss_pkg.
module gss_cmp (
    input  logic signed [gss_pkg::RPM_W-1:0] a,
    input  logic signed [gss_pkg::RPM_W-1:0] b,
    output gss_pkg::cmp_res_t                res
);

    assign res.lt = (a < b);
    assign res.gt = (a > b);

endmodule

>>> design/gear_shift_selector.sv
// gear_shift_selector: top level, sequencer around the shared comparator.
// Depends on gss_pkg, gss_cfg and gss_cmp.

// Takes one request per sample (signed RPM and a wrapping millisecond time)
// and returns one request holding the selected gear. An accepted sample runs
// through ST_PREP and ST_UP, then through ST_SCAN when the downshift scan runs
// and steps down k gears (up to MAX_GEARS - 1); ST_DONE loads the result into
// the output register (a standing or reverse sample goes from ST_PREP straight
// to ST_DONE). s_tready returns when the result is loaded, so a new sample is
// taken only once the previous one has left the sequencer, and ST_DONE waits
// until the output register is free. The sequencing is set by the single signed
// comparator: it is used once for the falling-RPM test, once for the upshift
// test and once per visited gear of the downshift scan. s_tready is high only
// while the sequencer is idle; a finished result sits in the output register,
// so the next sample can be taken while the previous result is still waiting.
// Configuration writes are always accepted (cfg_ready is tied high) and
// must only be issued while no sample is in flight.
module gear_shift_selector #(
    parameter int MAX_GEARS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gss_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] rpm, [47:16] now_ms
    // result requests
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gss_pkg::M_TDATA_W-1:0]      m_tdata,   // [3:0] selected_gear, [7:4] zero
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,   // falling test on comparator, guard check
        ST_UP,     // upshift test on comparator
        ST_SCAN,   // downshift scan, one gear per cycle
        ST_DONE    // hand result to output register
    } state_t;

    state_t                              state_reg, state_next;
    logic signed [gss_pkg::RPM_W-1:0]    rpm_reg, rpm_next;
    logic [gss_pkg::TIME_W-1:0]          now_reg, now_next;
    logic signed [gss_pkg::RPM_W-1:0]    prev_rpm_reg, prev_rpm_next;
    logic [gss_pkg::TIME_W-1:0]          last_shift_reg, last_shift_next;
    logic [gss_pkg::GEAR_W-1:0]          cur_gear_reg, cur_gear_next;
    logic                                falling_reg, falling_next;
    logic                                guard_ok_reg, guard_ok_next;
    logic                                shifted_reg, shifted_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [gss_pkg::GEAR_W-1:0]          m_gear_reg, m_gear_next;

    gss_pkg::thr_req_t                   thr_req;
    logic signed [gss_pkg::RPM_W-1:0]    thr_value;
    logic [gss_pkg::GEAR_W-1:0]          count_eff;
    logic [gss_pkg::GUARD_W-1:0]         guard_ms;
    logic signed [gss_pkg::RPM_W-1:0]    cmp_b;
    gss_pkg::cmp_res_t                   cmp_res;
    logic [gss_pkg::TIME_W-1:0]          elapsed;
    logic                                s_accept;

    gss_cfg #(
        .MAX_GEARS (MAX_GEARS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr_req   (thr_req),
        .thr_value (thr_value),
        .count_eff (count_eff),
        .guard_ms  (guard_ms)
    );

    // comparator operand B: previous sample in PREP, else a threshold lane
    assign cmp_b = (state_reg == ST_PREP) ? prev_rpm_reg : thr_value;

    gss_cmp u_cmp (
        .a   (rpm_reg),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // upshift lanes in ST_UP; the scan picks braking lanes while RPM falls, down lanes otherwise
    always_comb begin
        thr_req.gear = cur_gear_reg;
        if (state_reg == ST_UP)
            thr_req.kind = gss_pkg::THR_UP;
        else if (falling_reg)
            thr_req.kind = gss_pkg::THR_BRAKE;
        else
            thr_req.kind = gss_pkg::THR_DOWN;
    end

    assign elapsed   = now_reg - last_shift_reg;   // wraps modulo 2^32
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(gss_pkg::M_TDATA_W - gss_pkg::GEAR_W){1'b0}}, m_gear_reg};

    always_comb begin
        state_next      = state_reg;
        rpm_next        = rpm_reg;
        now_next        = now_reg;
        prev_rpm_next   = prev_rpm_reg;
        last_shift_next = last_shift_reg;
        cur_gear_next   = cur_gear_reg;
        falling_next    = falling_reg;
        guard_ok_next   = guard_ok_reg;
        shifted_next    = shifted_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_gear_next     = m_gear_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    rpm_next   = s_tdata[gss_pkg::RPM_W-1:0];
                    now_next   = s_tdata[gss_pkg::RPM_W +: gss_pkg::TIME_W];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                falling_next  = cmp_res.lt;
                guard_ok_next = (elapsed > {{(gss_pkg::TIME_W - gss_pkg::GUARD_W){1'b0}},
                                            guard_ms});
                shifted_next  = 1'b0;
                // standing or reverse: gear 1, no guard, shift time untouched
                if (rpm_reg[gss_pkg::RPM_W-1] || rpm_reg == '0) begin
                    cur_gear_next = gss_pkg::GEAR_ONE;
                    prev_rpm_next = rpm_reg;
                    state_next    = ST_DONE;
                end else begin
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (cur_gear_reg < count_eff && cmp_res.gt && !falling_reg
                    && guard_ok_reg) begin
                    cur_gear_next   = cur_gear_reg + gss_pkg::GEAR_ONE;
                    last_shift_next = now_reg;
                    prev_rpm_next   = rpm_reg;
                    state_next      = ST_DONE;
                end else if (cur_gear_reg > gss_pkg::GEAR_ONE && guard_ok_reg) begin
                    state_next = ST_SCAN;
                end else begin
                    prev_rpm_next = rpm_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (cur_gear_reg > gss_pkg::GEAR_ONE && cmp_res.lt) begin
                    cur_gear_next = cur_gear_reg - gss_pkg::GEAR_ONE;
                    shifted_next  = 1'b1;
                end else begin
                    if (shifted_reg)
                        last_shift_next = now_reg;
                    prev_rpm_next = rpm_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_gear_next   = cur_gear_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_rpm_reg   <= '0;
            last_shift_reg <= '0;
            cur_gear_reg   <= gss_pkg::GEAR_ONE;
            m_tvalid_reg   <= 1'b0;
            falling_reg    <= 1'b0;
            guard_ok_reg   <= 1'b0;
            shifted_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_rpm_reg   <= prev_rpm_next;
            last_shift_reg <= last_shift_next;
            cur_gear_reg   <= cur_gear_next;
            m_tvalid_reg   <= m_tvalid_next;
            falling_reg    <= falling_next;
            guard_ok_reg   <= guard_ok_next;
            shifted_reg    <= shifted_next;
        end
        rpm_reg    <= rpm_next;
        now_reg    <= now_next;
        m_gear_reg <= m_gear_next;
    end

`ifndef SYNTH
    // gear stays within 1..MAX_GEARS
    a_gear_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_gear_reg != '0 && cur_gear_reg <= gss_pkg::GEAR_W'(MAX_GEARS))
        else $error("current gear out of range");

    // an accepted sample starts the sequence
    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_PREP)
        else $error("accepted sample did not start sequencing");

    // a freshly loaded result carries the current gear
    a_result_gear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && m_gear_reg == cur_gear_reg))
        else $error("result does not match current gear");

    // shift time moves only out of the upshift or scan steps
    a_shift_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_shift_reg != $past(last_shift_reg))
        |-> ($past(state_reg) == ST_UP || $past(state_reg) == ST_SCAN))
        else $error("shift time changed outside a shift");
`endif

endmodule

>>> test/tb_gear_shift_selector.sv
// tb_gear_shift_selector: self-checking bench for the gear shift selector.
// Depends on gss_pkg and gear_shift_selector; a directed table and then random drive
// cycles, checked against hand-typed gears or an in-bench model of the gear logic.
module tb_gear_shift_selector;

    localparam int MAX_GEARS     = 8;
    localparam int SETTLE_CYCLES = 4 + MAX_GEARS + 2;  // worst sample latency plus margin
    localparam int HOLD_CYCLES   = 400;                // long receiver hold-off
    localparam int STALL_LIMIT   = 4000;               // cycles without any handshake
    localparam int RANDOM_ITEMS  = 185;                // per random setting, six settings

    typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

    // one directed step: a sample (arg0 = rpm, arg1 = now_ms) or a register write
    // (arg0 = index, arg1 = data); gear != 0 marks a hand-typed expectation
    typedef struct packed {
        row_kind_t                  kind;
        logic [63:0]                arg0;
        logic [63:0]                arg1;
        logic [gss_pkg::GEAR_W-1:0] gear;
    } dir_row_t;

    typedef struct packed {
        logic signed [gss_pkg::RPM_W-1:0] rpm;
        logic [gss_pkg::TIME_W-1:0]       now_ms;
        logic [gss_pkg::GEAR_W-1:0]       gear;   // 0: take the prediction
    } sample_t;

    function automatic logic [63:0] pack4(input int g0, input int g1, input int g2,
                                          input int g3);
        return {16'(g3), 16'(g2), 16'(g1), 16'(g0)};
    endfunction

    function automatic dir_row_t row_sample(input int rpm, input logic [31:0] now_ms,
                                            input int gear);
        return '{kind: ROW_SAMPLE, arg0: 64'(16'(rpm)), arg1: 64'(now_ms),
                 gear: gss_pkg::GEAR_W'(gear)};
    endfunction

    function automatic dir_row_t row_cfg(input logic [gss_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [63:0] data);
        return '{kind: ROW_CFG, arg0: 64'(idx), arg1: data, gear: '0};
    endfunction

    // Directed part. The first block runs on reset settings (six gears, no guard,
    // all thresholds zero), so every gear there can be read off directly.
    localparam dir_row_t DIR_ROWS [37] = '{
        row_sample(0,      32'd0, 1),            // standing
        row_sample(-32768, 32'd5, 1),            // most negative rpm, reverse
        row_sample(100,    32'd0, 1),            // zero elapsed: guard not passed
        row_sample(100,    32'd1, 2),
        row_sample(32767,  32'd2, 3),            // top rpm
        row_sample(32767,  32'd3, 4),
        row_sample(32767,  32'd4, 5),
        row_sample(32767,  32'd5, 6),
        row_sample(32767,  32'd6, 6),            // gear count reached
        row_sample(1,      32'd7, 6),            // falling, braking thresholds at zero
        row_sample(0,      32'hFFFF_FFFF, 1),    // top time, standing
        row_sample(1,      32'hFFFF_FFFF, 2),
        row_sample(1,      32'd0, 3),            // timer wrap: elapsed is one
        row_cfg(gss_pkg::CFG_GEAR_COUNT, 64'd8),
        row_cfg(gss_pkg::CFG_GUARD_MS,   64'd0),
        row_cfg(gss_pkg::CFG_UP_LOW,     pack4(1000, 2000, 3000, 4000)),
        row_cfg(gss_pkg::CFG_UP_HIGH,    pack4(5000, 6000, 7000, 32767)),
        row_cfg(gss_pkg::CFG_DOWN_LOW,   pack4(-32768, 800, 1500, 4100)),
        row_cfg(gss_pkg::CFG_DOWN_HIGH,  pack4(4500, 5200, 6000, 6800)),
        row_cfg(gss_pkg::CFG_BRAKE_LOW,  pack4(0, 1200, 2000, 2800)),
        row_cfg(gss_pkg::CFG_BRAKE_HIGH, pack4(3500, 4200, 5000, 6000)),
        row_sample(32767,  32'd10, 0),           // climb to the top gear
        row_sample(32767,  32'd11, 0),
        row_sample(32767,  32'd12, 0),
        row_sample(32767,  32'd13, 0),
        row_sample(32767,  32'd14, 0),
        row_sample(4000,   32'd20, 0),           // braking, several gears at once
        row_sample(4000,   32'd30, 0),           // steady rpm, normal multi-step down
        row_sample(32767,  32'h8000_0000, 0),
        row_cfg(gss_pkg::CFG_GEAR_COUNT, 64'hFFFF_FFFF_FFFF_FFF0),   // zero count acts as one
        row_sample(4000,   32'h8000_0010, 0),    // count below current gear
        row_cfg(gss_pkg::CFG_GEAR_COUNT, 64'hA5A5_A5A5_A5A5_A5AF),   // count above the maximum
        row_sample(32767,  32'h8000_0020, 0),
        row_cfg(gss_pkg::CFG_GUARD_MS,   64'h1234_5678_9ABC_FFFF),   // largest guard
        row_sample(32767,  32'h8000_0030, 0),
        row_sample(32767,  32'h8001_001F, 0),    // elapsed equals guard: no shift
        row_sample(32767,  32'h8001_0020, 0)     // elapsed one past guard
    };

    // DUT ports
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [gss_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] rpm, [47:16] now_ms
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [gss_pkg::M_TDATA_W-1:0]  m_tdata;          // [3:0] selected_gear, [7:4] zero
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gss_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // bench model of the selector: settings mirror and gear state
    logic [63:0]                      cfg_reg [8];
    logic [gss_pkg::GEAR_W-1:0]       cur_gear      = gss_pkg::GEAR_ONE;
    logic signed [gss_pkg::RPM_W-1:0] prev_rpm      = '0;
    logic [gss_pkg::TIME_W-1:0]       last_shift_ms = '0;

    sample_t                          sample_q [$];   // samples waiting to be offered
    logic [gss_pkg::GEAR_W-1:0]       gear_q [$];     // gears expected on the result side
    sample_t                          offered;
    bit                               in_flight = 1'b0;
    logic [gss_pkg::GEAR_W-1:0]       want;
    int                               mismatches = 0;
    int                               send_idle_pct = 0;
    int                               recv_idle_pct = 0;
    int                               hold_seq = 0;
    int                               hold_seen = 0;
    int                               hold_left = 0;
    int                               idle_run = 0;
    logic [gss_pkg::TIME_W-1:0]       clock_ms = '0;

    gear_shift_selector #(.MAX_GEARS(MAX_GEARS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Signed threshold of one gear; each kind spans a low (gears 1-4) and a
    // high (gears 5-8) register, lowest gear in the lowest lane.
    function automatic logic signed [gss_pkg::RPM_W-1:0] gear_threshold(
        input gss_pkg::thr_kind_t kind, input int gear);
        int          lane;
        int          base;
        logic [63:0] word;
        case (kind)
            gss_pkg::THR_UP:   base = int'(gss_pkg::CFG_UP_LOW);
            gss_pkg::THR_DOWN: base = int'(gss_pkg::CFG_DOWN_LOW);
            default:           base = int'(gss_pkg::CFG_BRAKE_LOW);
        endcase
        lane = (gear - 1) & 7;
        word = cfg_reg[(base + lane / 4) & 7];
        return word[16 * (lane % 4) +: 16];
    endfunction

    // Gear after one sample; advances the model state.
    function automatic logic [gss_pkg::GEAR_W-1:0] next_gear(
        input logic signed [gss_pkg::RPM_W-1:0] rpm,
        input logic [gss_pkg::TIME_W-1:0] now_ms);
        logic [gss_pkg::TIME_W-1:0] elapsed;
        logic                       falling;
        logic                       guard_ok;
        int                         count;
        int                         target;
        gss_pkg::thr_kind_t         scan_kind;
        elapsed  = now_ms - last_shift_ms;   // wraps modulo 2^32
        falling  = rpm < prev_rpm;
        guard_ok = elapsed > gss_pkg::TIME_W'(
                       cfg_reg[gss_pkg::CFG_GUARD_MS][gss_pkg::GUARD_W-1:0]);
        count    = int'(cfg_reg[gss_pkg::CFG_GEAR_COUNT][gss_pkg::GEAR_W-1:0]);
        if (count < 1) count = 1;
        if (count > MAX_GEARS) count = MAX_GEARS;
        if (rpm <= 0) begin
            cur_gear = gss_pkg::GEAR_ONE;
        end else if (int'(cur_gear) < count
                     && rpm > gear_threshold(gss_pkg::THR_UP, cur_gear)
                     && !falling && guard_ok) begin
            cur_gear      = cur_gear + 1'b1;
            last_shift_ms = now_ms;
        end else if (cur_gear > gss_pkg::GEAR_ONE && guard_ok) begin
            scan_kind = falling ? gss_pkg::THR_BRAKE : gss_pkg::THR_DOWN;
            target    = int'(cur_gear);
            while (target > 1 && rpm < gear_threshold(scan_kind, target))
                target--;
            if (target != int'(cur_gear)) begin
                cur_gear      = gss_pkg::GEAR_W'(target);
                last_shift_ms = now_ms;
            end
        end
        prev_rpm = rpm;
        return cur_gear;
    endfunction

    // Result check first, then sample acceptance and the next offer. Keeping both
    // in one process makes the expected-gear queue order independent of the
    // scheduler.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (gear_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = gear_q.pop_front();
                    if (m_tdata !== gss_pkg::M_TDATA_W'(want)) begin
                        $display("%0t: selected_gear mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // the model always runs, so typed rows keep its state in step
                want = next_gear(offered.rpm, offered.now_ms);
                gear_q.push_back(offered.gear != '0 ? offered.gear : want);
                in_flight = 1'b0;
            end
            if (!in_flight && sample_q.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
                offered   = sample_q.pop_front();
                in_flight = 1'b1;
                s_tvalid <= 1'b1;
                s_tdata  <= {offered.now_ms, offered.rpm};
            end else if (!in_flight) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request so the
    // output register fills and the block stops taking samples.
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
                idle_run <= 0;
            end else if (idle_run >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_run <= idle_run + 1;
            end
        end
    end

    // Leaves cfg_valid high so back-to-back writes need no gap; caller lowers it.
    task automatic write_reg(input logic [gss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gss_pkg::CFG_GEAR_COUNT: cfg_reg[idx] = 64'(data[gss_pkg::GEAR_W-1:0]);
            gss_pkg::CFG_GUARD_MS:   cfg_reg[idx] = 64'(data[gss_pkg::GUARD_W-1:0]);
            default:                 cfg_reg[idx] = data;
        endcase
    endtask

    // Wait until every sample is taken and every result is back, then let the
    // sequencer settle before touching the registers.
    task automatic drain();
        do @(posedge aclk);
        while (sample_q.size() != 0 || in_flight || gear_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all eight registers. Plausible upshift points rise with the gear,
    // with braking at or above the normal down point; wild ones are raw random bits.
    task automatic apply_setting(input logic [gss_pkg::GEAR_W-1:0] count,
                                 input logic [gss_pkg::GUARD_W-1:0] guard, input bit wild);
        int                               g;
        int                               idx;
        logic signed [gss_pkg::RPM_W-1:0] up [8];
        logic signed [gss_pkg::RPM_W-1:0] dn [8];
        logic signed [gss_pkg::RPM_W-1:0] br [8];
        for (g = 0; g < 8; g++) begin
            up[g] = 16'(1500 + 800 * g + int'($urandom_range(600)));
            dn[g] = 16'(int'(up[g]) / 2 - int'($urandom_range(400)));
            br[g] = 16'(int'(dn[g]) + int'($urandom_range(700)));
        end
        // junk above the register width must be dropped
        write_reg(gss_pkg::CFG_GEAR_COUNT, {$urandom, 28'($urandom), count});
        write_reg(gss_pkg::CFG_GUARD_MS, {$urandom, 16'($urandom), guard});
        if (wild) begin
            for (idx = int'(gss_pkg::CFG_UP_LOW); idx <= int'(gss_pkg::CFG_BRAKE_HIGH);
                 idx++)
                write_reg(gss_pkg::CFG_IDX_W'(idx), {$urandom, $urandom});
        end else begin
            write_reg(gss_pkg::CFG_UP_LOW,     pack4(up[0], up[1], up[2], up[3]));
            write_reg(gss_pkg::CFG_UP_HIGH,    pack4(up[4], up[5], up[6], up[7]));
            write_reg(gss_pkg::CFG_DOWN_LOW,   pack4(dn[0], dn[1], dn[2], dn[3]));
            write_reg(gss_pkg::CFG_DOWN_HIGH,  pack4(dn[4], dn[5], dn[6], dn[7]));
            write_reg(gss_pkg::CFG_BRAKE_LOW,  pack4(br[0], br[1], br[2], br[3]));
            write_reg(gss_pkg::CFG_BRAKE_HIGH, pack4(br[4], br[5], br[6], br[7]));
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly drive cycles: an rpm random walk with accelerating runs, braking
    // drops and the odd standstill, time stepping mostly past the guard. The
    // rest is raw noise on both fields.
    task automatic queue_random(input int n, input int unsigned guard);
        int      left;
        int      len;
        int      k;
        int      rpm_walk;
        int      delta;
        sample_t it;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                len      = $urandom_range(10, 40);
                rpm_walk = $urandom_range(300, 2500);
                for (k = 0; k < len && left > 0; k++) begin
                    case ($urandom_range(9))
                        0:       delta = -int'($urandom_range(4000));
                        1, 2:    delta = -int'($urandom_range(600));
                        default: delta = $urandom_range(900);
                    endcase
                    rpm_walk += delta;
                    if (rpm_walk < 1) rpm_walk = 1;
                    if (rpm_walk > 12000) rpm_walk = 12000;
                    if ($urandom_range(3) == 0)
                        clock_ms += $urandom_range(guard);
                    else
                        clock_ms += guard + $urandom_range(1, 60);
                    if ($urandom_range(29) == 0)
                        it.rpm = 16'(0 - int'($urandom_range(32768)));
                    else
                        it.rpm = 16'(rpm_walk);
                    it.now_ms = clock_ms;
                    it.gear   = '0;
                    sample_q.push_back(it);
                    left--;
                end
            end else begin
                it.rpm    = 16'($urandom);
                it.now_ms = $urandom;
                it.gear   = '0;
                sample_q.push_back(it);
                left--;
            end
        end
    endtask

    initial begin
        int      r;
        int      s;
        bit      was_cfg;
        sample_t it;
        logic [gss_pkg::GEAR_W-1:0]  count;
        logic [gss_pkg::GUARD_W-1:0] guard;
        bit      wild;

        for (r = 0; r < 8; r++) cfg_reg[r] = '0;
        cfg_reg[gss_pkg::CFG_GEAR_COUNT] = 64'(gss_pkg::GEAR_COUNT_RESET);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // phase one: sender idles rarely, receiver often
        send_idle_pct = 6;
        recv_idle_pct = 61;

        // directed table; registers change only once the block is idle
        was_cfg = 1'b0;
        for (r = 0; r < $size(DIR_ROWS); r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                if (!was_cfg) drain();
                write_reg(gss_pkg::CFG_IDX_W'(DIR_ROWS[r].arg0), DIR_ROWS[r].arg1);
                was_cfg = 1'b1;
                if (r + 1 == $size(DIR_ROWS) || DIR_ROWS[r + 1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end else begin
                it.rpm    = DIR_ROWS[r].arg0[gss_pkg::RPM_W-1:0];
                it.now_ms = DIR_ROWS[r].arg1[gss_pkg::TIME_W-1:0];
                it.gear   = DIR_ROWS[r].gear;
                sample_q.push_back(it);
                was_cfg = 1'b0;
            end
        end
        drain();

        // random part: six settings, two per idling phase
        for (s = 0; s < 6; s++) begin
            if (s == 2) begin
                send_idle_pct = 61;
                recv_idle_pct = 6;
            end else if (s == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (s)
                0: begin count = 4'd8;  guard = 16'($urandom_range(20));  wild = 1'b0; end
                1: begin count = 4'($urandom_range(15)); guard = 16'hFFFF; wild = 1'b1; end
                2: begin count = 4'd1;  guard = 16'($urandom_range(20));  wild = 1'b0; end
                3: begin count = 4'd15; guard = 16'($urandom_range(300)); wild = 1'b0; end
                4: begin
                    count = 4'($urandom_range(2, 8));
                    guard = 16'($urandom_range(1000));
                    wild  = 1'b1;
                end
                default: begin count = 4'd8; guard = '0; wild = 1'b0; end
            endcase
            // last setting starts just below the wrap point of the timer
            clock_ms = (s == 5) ? 32'hFFFF_FF00 : $urandom;
            apply_setting(count, guard, wild);
            if (s == 0) hold_seq <= hold_seq + 1;   // back up the result side
            queue_random(RANDOM_ITEMS, guard);
            drain();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
